// ----- rtl/npc_pkg.sv -----
// shared command and status types for the number property classifier
package npc_pkg;

   localparam int REQ_VALUE_WIDTH = 16;

   typedef struct packed {
      logic load;
      logic b_init;
      logic sq;
      logic sel_n;
      logic div_start;
      logic acc_a;
      logic take;
      logic rep_set;
      logic t_inc;
      logic latch;
   } npc_cmd_type;

   typedef struct packed {
      logic sq_le;
      logic div_done;
      logic rem_zero;
   } npc_sts_type;

endpackage

// ----- rtl/npc_div.sv -----
// restoring divider, one quotient bit per cycle
module npc_div #(
   parameter int W = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quot,
   output logic [W-1:0] rem
);
   localparam int CW = $clog2(W);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quot_ff, quot_in;
   logic [W-1:0]  div_ff, div_in;
   logic [W:0]    shifted;
   logic [W:0]    diff;

   assign shifted = {rem_ff, quot_ff[W-1]};
   assign diff    = shifted - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quot_in = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[W]) begin
            rem_in  = diff[W-1:0];
            quot_in = {quot_ff[W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[W-1:0];
            quot_in = {quot_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      div_ff  <= div_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

// ----- rtl/npc_datapath.sv -----
// datapath: trial divisor, square, divisor sum, factoring and result flags
module npc_datapath #(
   parameter int W = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [npc_pkg::REQ_VALUE_WIDTH-1:0]  req_value,
   input  npc_pkg::npc_cmd_type                 cmd,
   output npc_pkg::npc_sts_type                 sts,
   output logic                                 is_perfect,
   output logic                                 is_prime,
   output logic                                 is_perfect_square,
   output logic                                 is_sphenic
);
   import npc_pkg::*;

   localparam int DW = (W + 1) / 2 + 2;
   localparam int PW = 2 * DW;
   localparam int SW = W + 3;

   logic [W-1:0]  v_ff, v_in;
   logic [W-1:0]  n_ff, n_in;
   logic [DW-1:0] t_ff, t_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [2:0]    dist_ff, dist_in;
   logic          sq_ff, sq_in;
   logic          rep_ff, rep_in;
   logic          perf_ff, perf_in;
   logic          prime_ff, prime_in;
   logic          square_ff, square_in;
   logic          sphen_ff, sphen_in;

   logic          div_done;
   logic [W-1:0]  quot;
   logic [W-1:0]  rem;
   logic [W-1:0]  target;
   logic [2:0]    dist_final;
   logic          v_zero;

   npc_div #(.W(W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (cmd.sel_n ? n_ff : v_ff),
      .divisor  (W'(t_ff)),
      .done     (div_done),
      .quot     (quot),
      .rem      (rem)
   );

   assign target       = cmd.sel_n ? n_ff : v_ff;
   assign sts.sq_le    = prod_ff <= PW'(target);
   assign sts.div_done = div_done;
   assign sts.rem_zero = rem == '0;
   assign v_zero       = v_ff == '0;

   always_comb begin
      dist_final = dist_ff;
      if (n_ff > W'(1) && dist_ff != 3'd7) begin
         dist_final = dist_ff + 3'd1;
      end
   end

   always_comb begin
      v_in      = v_ff;
      n_in      = n_ff;
      t_in      = t_ff;
      prod_in   = prod_ff;
      sum_in    = sum_ff;
      dist_in   = dist_ff;
      sq_in     = sq_ff;
      rep_in    = rep_ff;
      perf_in   = perf_ff;
      prime_in  = prime_ff;
      square_in = square_ff;
      sphen_in  = sphen_ff;
      if (cmd.load) begin
         v_in    = W'(req_value);
         t_in    = DW'(1);
         sum_in  = '0;
         dist_in = '0;
         sq_in   = 1'b0;
         rep_in  = 1'b0;
      end
      if (cmd.b_init) begin
         n_in = v_ff;
         t_in = DW'(2);
      end
      if (cmd.sq) begin
         prod_in = PW'(t_ff) * PW'(t_ff);
      end
      if (cmd.div_start && !cmd.sel_n && prod_ff == PW'(v_ff)) begin
         sq_in = 1'b1;
      end
      if (cmd.acc_a && sts.rem_zero) begin
         if (quot != W'(t_ff)) begin
            sum_in = sum_ff + SW'(t_ff) + SW'(quot);
         end else begin
            sum_in = sum_ff + SW'(t_ff);
         end
      end
      if (cmd.take) begin
         n_in = quot;
         if (dist_ff != 3'd7) begin
            dist_in = dist_ff + 3'd1;
         end
      end
      if (cmd.rep_set) begin
         rep_in = 1'b1;
      end
      if (cmd.t_inc) begin
         t_in = t_ff + DW'(1);
      end
      if (cmd.latch) begin
         perf_in   = !v_zero && sum_ff == (SW'(v_ff) << 1);
         prime_in  = v_ff >= W'(2) && sum_ff == SW'(v_ff) + SW'(1);
         square_in = !v_zero && sq_ff;
         sphen_in  = !v_zero && !rep_ff && dist_final == 3'd3;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         perf_ff   <= 1'b0;
         prime_ff  <= 1'b0;
         square_ff <= 1'b0;
         sphen_ff  <= 1'b0;
      end else begin
         perf_ff   <= perf_in;
         prime_ff  <= prime_in;
         square_ff <= square_in;
         sphen_ff  <= sphen_in;
      end
      v_ff    <= v_in;
      n_ff    <= n_in;
      t_ff    <= t_in;
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
      dist_ff <= dist_in;
      sq_ff   <= sq_in;
      rep_ff  <= rep_in;
   end

   assign is_perfect        = perf_ff;
   assign is_prime          = prime_ff;
   assign is_perfect_square = square_ff;
   assign is_sphenic        = sphen_ff;

endmodule

// ----- rtl/npc_ctrl.sv -----
// controller state machine sequencing divisor sum and factoring passes
module npc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  npc_pkg::npc_sts_type  sts,
   output npc_pkg::npc_cmd_type  cmd,
   output logic                  busy,
   output logic                  rsp_valid
);
   import npc_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_A_SQ  = 4'd1;
   localparam logic [3:0] ST_A_CMP = 4'd2;
   localparam logic [3:0] ST_A_DIV = 4'd3;
   localparam logic [3:0] ST_B_SQ  = 4'd4;
   localparam logic [3:0] ST_B_CMP = 4'd5;
   localparam logic [3:0] ST_B_DIV = 4'd6;
   localparam logic [3:0] ST_B_RE  = 4'd7;
   localparam logic [3:0] ST_B_DV2 = 4'd8;
   localparam logic [3:0] ST_FIN   = 4'd9;
   localparam logic [3:0] ST_OUT   = 4'd10;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_A_SQ;
            end
         end
         ST_A_SQ: begin
            cmd.sq   = 1'b1;
            state_in = ST_A_CMP;
         end
         ST_A_CMP: begin
            if (sts.sq_le) begin
               cmd.div_start = 1'b1;
               state_in      = ST_A_DIV;
            end else begin
               cmd.b_init = 1'b1;
               state_in   = ST_B_SQ;
            end
         end
         ST_A_DIV: begin
            if (sts.div_done) begin
               cmd.acc_a = 1'b1;
               cmd.t_inc = 1'b1;
               state_in  = ST_A_SQ;
            end
         end
         ST_B_SQ: begin
            cmd.sq    = 1'b1;
            cmd.sel_n = 1'b1;
            state_in  = ST_B_CMP;
         end
         ST_B_CMP: begin
            cmd.sel_n = 1'b1;
            if (sts.sq_le) begin
               cmd.div_start = 1'b1;
               state_in      = ST_B_DIV;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_B_DIV: begin
            cmd.sel_n = 1'b1;
            if (sts.div_done) begin
               if (sts.rem_zero) begin
                  cmd.take = 1'b1;
                  state_in = ST_B_RE;
               end else begin
                  cmd.t_inc = 1'b1;
                  state_in  = ST_B_SQ;
               end
            end
         end
         ST_B_RE: begin
            cmd.sel_n     = 1'b1;
            cmd.div_start = 1'b1;
            state_in      = ST_B_DV2;
         end
         ST_B_DV2: begin
            cmd.sel_n = 1'b1;
            if (sts.div_done) begin
               if (sts.rem_zero) begin
                  cmd.rep_set = 1'b1;
                  state_in    = ST_FIN;
               end else begin
                  cmd.t_inc = 1'b1;
                  state_in  = ST_B_SQ;
               end
            end
         end
         ST_FIN: begin
            cmd.sel_n = 1'b1;
            cmd.latch = 1'b1;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = state_ff == ST_OUT;

endmodule

// ----- rtl/number_property_classifier.sv -----
// Classifies one positive integer per item as perfect, prime, perfect square and sphenic
// by trial division. Raise start with req_value while busy is low; the item is taken at
// that edge and busy stays high until the result has been shown. The result appears on
// the rsp_ ports for exactly one cycle, marked by rsp_valid, and must be captured then.
// A shared divider producing one quotient bit per cycle sets the pace, and each trial
// divisor runs a full division. The divisor-sum pass tries every divisor up to the
// square root of the value, and the factoring pass tries divisors up to the square root
// of the shrinking cofactor, so items with larger values and cofactors take longer.
// Only the low VALUE_BITS bits of req_value are used; a zero value gives all flags low.
module number_property_classifier #(
   parameter int VALUE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [npc_pkg::REQ_VALUE_WIDTH-1:0] req_value,
   output logic                                rsp_valid,
   output logic                                rsp_is_perfect,
   output logic                                rsp_is_prime,
   output logic                                rsp_is_perfect_square,
   output logic                                rsp_is_sphenic
);
   import npc_pkg::*;

   npc_cmd_type cmd;
   npc_sts_type sts;

   npc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   npc_datapath #(.W(VALUE_BITS)) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_value         (req_value),
      .cmd               (cmd),
      .sts               (sts),
      .is_perfect        (rsp_is_perfect),
      .is_prime          (rsp_is_prime),
      .is_perfect_square (rsp_is_perfect_square),
      .is_sphenic        (rsp_is_sphenic)
   );

`ifndef NO_ASSERTIONS
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_result_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result shown while idle");

   a_prime_square: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_prime && rsp_is_perfect_square))
      else $error("item flagged both prime and square");

   a_prime_sphenic: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_prime && rsp_is_sphenic))
      else $error("item flagged both prime and sphenic");
`endif

endmodule

// ----- dv/npc_checker.sv -----
// checker for the number property classifier: predicts the flags of each item and compares
module npc_checker #(
   parameter int VALUE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic [npc_pkg::REQ_VALUE_WIDTH-1:0] req_value,
   input  logic                                rsp_valid,
   input  logic                                rsp_is_perfect,
   input  logic                                rsp_is_prime,
   input  logic                                rsp_is_perfect_square,
   input  logic                                rsp_is_sphenic,
   output int                                  error_count,
   output int                                  pending
);

   typedef struct packed {
      logic perfect;
      logic prime;
      logic square;
      logic sphenic;
   } flag_set_type;

   typedef struct {
      logic [npc_pkg::REQ_VALUE_WIDTH-1:0] value;
      flag_set_type                        flags;
   } classified_item_type;

   classified_item_type expected_flags_q[$];
   int                  fail_tally = 0;

   function automatic flag_set_type classify_number(
      input logic [npc_pkg::REQ_VALUE_WIDTH-1:0] value
   );
      longint unsigned v;
      longint unsigned root;
      longint unsigned div_sum;
      longint unsigned cofactor;
      longint unsigned d;
      int              distinct;
      bit              repeated;
      flag_set_type    f;
      v = longint'(value) & ((64'd1 << VALUE_BITS) - 64'd1);
      f = '0;
      if (v == 0)
         return f;
      root = 0;
      while ((root + 1) * (root + 1) <= v)
         root++;
      // divisor pairs up to the root, the value itself included
      div_sum = 0;
      for (d = 1; d <= root; d++) begin
         if (v % d == 0) begin
            div_sum += d;
            if (v / d != d)
               div_sum += v / d;
         end
      end
      f.perfect = (div_sum - v == v);
      f.prime   = (v >= 2) && (div_sum - v == 1);
      f.square  = (root * root == v);
      cofactor = v;
      distinct = 0;
      repeated = 1'b0;
      for (d = 2; d * d <= cofactor && !repeated; d++) begin
         if (cofactor % d == 0) begin
            distinct++;
            cofactor = cofactor / d;
            if (cofactor % d == 0)
               repeated = 1'b1;
         end
      end
      if (cofactor > 1)
         distinct++;
      f.sphenic = !repeated && (distinct == 3);
      return f;
   endfunction

   always @(posedge clock) begin : monitor
      flag_set_type        actual;
      classified_item_type oldest;
      if (reset) begin
         expected_flags_q.delete();
      end else begin
         // results first: an item taken at this edge cannot answer at the same edge
         if (rsp_valid) begin
            actual = '{rsp_is_perfect, rsp_is_prime, rsp_is_perfect_square, rsp_is_sphenic};
            if (expected_flags_q.size() == 0) begin
               if (fail_tally < 10)
                  $display("mismatch: result with no item waiting, flags %b", actual);
               fail_tally++;
            end else begin
               oldest = expected_flags_q.pop_front();
               if (actual.perfect !== oldest.flags.perfect ||
                   actual.prime   !== oldest.flags.prime   ||
                   actual.square  !== oldest.flags.square  ||
                   actual.sphenic !== oldest.flags.sphenic) begin
                  if (fail_tally < 10)
                     $display({"mismatch: value %0d perfect/prime/square/sphenic ",
                               "expected %b %b %b %b got %b %b %b %b"},
                              oldest.value, oldest.flags.perfect, oldest.flags.prime,
                              oldest.flags.square, oldest.flags.sphenic, actual.perfect,
                              actual.prime, actual.square, actual.sphenic);
                  fail_tally++;
               end
            end
         end
         if (start && !busy)
            expected_flags_q.push_back('{req_value, classify_number(req_value)});
      end
      error_count <= fail_tally;
      pending     <= expected_flags_q.size();
   end

endmodule

// ----- dv/testbench.sv -----
// top of the number property classifier testbench: drives items and gives the verdict
module testbench;

   localparam int W            = npc_pkg::REQ_VALUE_WIDTH;
   localparam int VALUE_BITS   = 16;
   localparam int CYCLE_LIMIT  = 8_000_000;
   localparam int TAIL_CYCLES  = 10_000;
   localparam int RANDOM_ITEMS = 107;
   localparam int QUIET_ITEMS  = 20;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         start     = 1'b0;
   logic [W-1:0] req_value = '0;
   logic         busy;
   logic         rsp_valid;
   logic         rsp_is_perfect;
   logic         rsp_is_prime;
   logic         rsp_is_perfect_square;
   logic         rsp_is_sphenic;
   int           error_count;
   int           pending;
   int unsigned  cycle_count = 0;

   int unsigned  small_primes [15] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47};
   int unsigned  perfect_numbers [4] = '{6, 28, 496, 8128};
   logic [W-1:0] directed_values [23] = '{
      16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd6, 16'd12, 16'd28, 16'd30, 16'd49,
      16'd60, 16'd496, 16'd1001, 16'd8128, 16'd255, 16'd32768, 16'd21845, 16'd43690,
      16'd65025, 16'd65521, 16'd65534, 16'd65535, 16'd1155
   };

   always #5 clock = ~clock;

   number_property_classifier #(
      .VALUE_BITS(VALUE_BITS)
   ) u_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_value            (req_value),
      .rsp_valid            (rsp_valid),
      .rsp_is_perfect       (rsp_is_perfect),
      .rsp_is_prime         (rsp_is_prime),
      .rsp_is_perfect_square(rsp_is_perfect_square),
      .rsp_is_sphenic       (rsp_is_sphenic)
   );

   npc_checker #(
      .VALUE_BITS(VALUE_BITS)
   ) u_checker (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_value            (req_value),
      .rsp_valid            (rsp_valid),
      .rsp_is_perfect       (rsp_is_perfect),
      .rsp_is_prime         (rsp_is_prime),
      .rsp_is_perfect_square(rsp_is_perfect_square),
      .rsp_is_sphenic       (rsp_is_sphenic),
      .error_count          (error_count),
      .pending              (pending)
   );

   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         cycle_count <= cycle_count + 1;
      end
   end

   // mostly small values, some full range, the rest shaped numbers
   function automatic logic [W-1:0] random_value();
      int unsigned kind;
      int unsigned a;
      int unsigned b;
      int unsigned c;
      int unsigned product;
      kind = $urandom_range(0, 99);
      if (kind < 55)
         return W'($urandom_range(0, 4095));
      if (kind < 70)
         return W'($urandom);
      if (kind < 80) begin
         do begin
            a = $urandom_range(0, 14);
            b = $urandom_range(0, 14);
            c = $urandom_range(0, 14);
            product = small_primes[a] * small_primes[b] * small_primes[c];
         end while (a == b || b == c || a == c || product > 65535);
         return W'(product);
      end
      if (kind < 85) begin
         // one prime squared times two others
         do begin
            a = $urandom_range(0, 14);
            b = $urandom_range(0, 14);
            c = $urandom_range(0, 14);
            product = small_primes[a] * small_primes[a] * small_primes[b] * small_primes[c];
         end while (a == b || b == c || a == c || product > 65535);
         return W'(product);
      end
      if (kind < 92) begin
         a = $urandom_range(1, 255);
         return W'(a * a);
      end
      if (kind < 96)
         return W'(perfect_numbers[$urandom_range(0, 3)]);
      return W'(small_primes[$urandom_range(0, 14)]);
   endfunction

   function automatic int idle_burst();
      return ($urandom_range(0, 1) == 1) ? $urandom_range(1, 16) : 0;
   endfunction

   // with a gap, hold off until the block is idle so the idle cycles reach it
   task automatic send_item(input logic [W-1:0] value, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         do @(posedge clock); while (busy);
         repeat (gap - 1) begin
            req_value <= W'($urandom);
            @(posedge clock);
         end
      end
      start     <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin
      int n;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_values[i])
         send_item(directed_values[i], idle_burst());
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3)
            wait_for_drain();
         send_item(random_value(), (n >= RANDOM_ITEMS - QUIET_ITEMS) ? 0 : idle_burst());
      end
      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && pending == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/npc_pkg.sv
rtl/npc_div.sv
rtl/npc_datapath.sv
rtl/npc_ctrl.sv
rtl/number_property_classifier.sv
dv/npc_checker.sv
dv/testbench.sv
